### src/fbba_pkg.sv
package fbba_pkg;

    localparam int MAP_SEGMENTS_DEF     = 4;
    localparam int BITS_PER_SEGMENT_DEF = 8192;
    localparam int CFG_W                = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;
    localparam int IDX_W                = 15;
    localparam int WORD_W               = 64;
    localparam int BIT_W                = 6;

    typedef enum logic [1:0] {
        CMD_TEST      = 2'd0,
        CMD_MARK_USED = 2'd1,
        CMD_MARK_FREE = 2'd2,
        CMD_FIND_FREE = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [IDX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] free_index;
        logic             found;
    } res_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic scan_init;
        logic acc_rd;
        logic acc_wr;
        logic scan_rd;
        logic scan_next;
        logic word_latch;
        logic word_rd;
        logic emit_acc;
        logic emit_none;
        logic emit_found;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic in_find;
        logic scan_end;
        logic scan_hit;
    } sts_t;

    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### src/fbba_ctrl.sv
module fbba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fbba_pkg::sts_t sts,
    output fbba_pkg::ctl_t ctl
);
    import fbba_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR     = 8'b0000_0001,
        ST_IDLE      = 8'b0000_0010,
        ST_ACC_ADDR  = 8'b0000_0100,
        ST_ACC_DATA  = 8'b0000_1000,
        ST_SCAN_ADDR = 8'b0001_0000,
        ST_SCAN_DATA = 8'b0010_0000,
        ST_WORD_ADDR = 8'b0100_0000,
        ST_WORD_DATA = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    if (sts.in_find)
                    begin
                        ctl.scan_init = 1'b1;
                        state_next    = ST_SCAN_ADDR;
                    end
                    else
                    begin
                        state_next = ST_ACC_ADDR;
                    end
                end
            end
            ST_ACC_ADDR:
            begin
                ctl.acc_rd = 1'b1;
                state_next = ST_ACC_DATA;
            end
            ST_ACC_DATA:
            begin
                ctl.acc_wr   = 1'b1;
                ctl.emit_acc = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SCAN_ADDR:
            begin
                if (sts.scan_end)
                begin
                    ctl.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ctl.scan_rd = 1'b1;
                    state_next  = ST_SCAN_DATA;
                end
            end
            ST_SCAN_DATA:
            begin
                if (sts.scan_hit)
                begin
                    ctl.word_latch = 1'b1;
                    state_next     = ST_WORD_ADDR;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                    state_next    = ST_SCAN_ADDR;
                end
            end
            ST_WORD_ADDR:
            begin
                ctl.word_rd = 1'b1;
                state_next  = ST_WORD_DATA;
            end
            ST_WORD_DATA:
            begin
                ctl.emit_found = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### src/fbba_dp.sv
module fbba_dp #(
    parameter int MAP_SEGMENTS     = fbba_pkg::MAP_SEGMENTS_DEF,
    parameter int BITS_PER_SEGMENT = fbba_pkg::BITS_PER_SEGMENT_DEF,
    localparam int TOTAL_BITS = MAP_SEGMENTS * BITS_PER_SEGMENT,
    localparam int MAP_WORDS  = TOTAL_BITS / 64,
    localparam int WC_W       = $clog2(MAP_WORDS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fbba_pkg::ctl_t   ctl,
    output fbba_pkg::sts_t   sts,
    input  fbba_pkg::req_t   request,
    input  logic [WC_W-1:0]  limit_words,
    output fbba_pkg::res_t   result,
    output logic             done
);
    import fbba_pkg::*;

    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int SUM_WORDS = (MAP_WORDS + WORD_W - 1) / WORD_W;
    localparam int SADDR_W   = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int SCNT_W    = SADDR_W + 1;
    localparam int CMP_W     = SCNT_W + BIT_W + 1;

    logic [WORD_W-1:0] map_mem [MAP_WORDS];
    logic [WORD_W-1:0] sum_mem [SUM_WORDS];
    logic [WORD_W-1:0] map_q;
    logic [WORD_W-1:0] sum_q;

    logic [WADDR_W-1:0] clr_cnt_reg;
    logic [WADDR_W-1:0] clr_cnt_next;
    req_t               req_reg;
    logic [SCNT_W-1:0]  scan_cnt_reg;
    logic [SCNT_W-1:0]  scan_cnt_next;
    logic [WADDR_W-1:0] word_reg;
    res_t               res_reg;
    res_t               res_next;
    logic               done_reg;

    logic [8:0]         blk_word;
    logic [WADDR_W-1:0] acc_waddr;
    logic [SADDR_W-1:0] acc_saddr;
    logic [BIT_W-1:0]   acc_bit;
    logic [BIT_W-1:0]   acc_sbit;
    logic               in_range;
    logic [WORD_W-1:0]  acc_onehot;
    logic [WORD_W-1:0]  new_word;
    logic [WORD_W-1:0]  new_sum;
    logic               mark;

    logic [CMP_W-1:0]   scan_base;
    logic [CMP_W-1:0]   scan_span;
    logic [WORD_W-1:0]  scan_mask;
    logic [WORD_W-1:0]  scan_cand;
    logic [WADDR_W-1:0] hit_word;

    logic [WADDR_W-1:0] map_raddr;
    logic [SADDR_W-1:0] sum_raddr;
    logic               map_we;
    logic [WADDR_W-1:0] map_waddr;
    logic [WORD_W-1:0]  map_wdata;
    logic               sum_we;
    logic [SADDR_W-1:0] sum_waddr;
    logic [WORD_W-1:0]  sum_wdata;

    assign blk_word   = req_reg.block_index[IDX_W-1:BIT_W];
    assign acc_waddr  = WADDR_W'(blk_word);
    assign acc_saddr  = SADDR_W'(acc_waddr >> BIT_W);
    assign acc_bit    = req_reg.block_index[BIT_W-1:0];
    assign acc_sbit   = BIT_W'(acc_waddr);
    assign in_range   = (32'(req_reg.block_index) < 32'(TOTAL_BITS));
    assign acc_onehot = WORD_W'(1) << acc_bit;
    assign new_word   = (req_reg.cmd == CMD_MARK_USED) ? (map_q | acc_onehot)
                                                       : (map_q & ~acc_onehot);
    always_comb
    begin
        new_sum           = sum_q;
        new_sum[acc_sbit] = &new_word;
    end
    assign mark = in_range &&
                  (req_reg.cmd == CMD_MARK_USED || req_reg.cmd == CMD_MARK_FREE);

    assign scan_base = CMP_W'({scan_cnt_reg, {BIT_W{1'b0}}});
    assign scan_span = CMP_W'(limit_words) - scan_base;
    assign scan_mask = (scan_span >= CMP_W'(WORD_W)) ? {WORD_W{1'b1}}
                     : ((WORD_W'(1) << scan_span[BIT_W-1:0]) - WORD_W'(1));
    assign scan_cand = ~sum_q & scan_mask;
    assign hit_word  = WADDR_W'({scan_cnt_reg[SADDR_W-1:0], first_zero(~scan_cand)});

    assign sts.clr_last = (clr_cnt_reg == WADDR_W'(MAP_WORDS - 1));
    assign sts.in_find  = (request.cmd == CMD_FIND_FREE);
    assign sts.scan_end = (CMP_W'(limit_words) <= scan_base);
    assign sts.scan_hit = |scan_cand;

    assign map_raddr = ctl.word_rd ? word_reg : acc_waddr;
    assign sum_raddr = ctl.scan_rd ? scan_cnt_reg[SADDR_W-1:0] : acc_saddr;

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = acc_waddr;
        map_wdata = new_word;
        sum_we    = 1'b0;
        sum_waddr = acc_saddr;
        sum_wdata = new_sum;
        if (ctl.clr_step)
        begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_reg;
            map_wdata = '0;
            sum_we    = (32'(clr_cnt_reg) < 32'(SUM_WORDS));
            sum_waddr = SADDR_W'(clr_cnt_reg);
            sum_wdata = '0;
        end
        else if (ctl.acc_wr)
        begin
            map_we = mark;
            sum_we = mark;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (ctl.acc_rd || ctl.word_rd)
        begin
            map_q <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (ctl.acc_rd || ctl.scan_rd)
        begin
            sum_q <= sum_mem[sum_raddr];
        end
    end

    assign clr_cnt_next  = ctl.clr_step ? (clr_cnt_reg + WADDR_W'(1)) : clr_cnt_reg;
    assign scan_cnt_next = ctl.scan_init ? '0
                         : (ctl.scan_next ? (scan_cnt_reg + SCNT_W'(1)) : scan_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= ctl.emit_acc | ctl.emit_none | ctl.emit_found;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (ctl.emit_acc)
        begin
            res_next.bit_value  = in_range & map_q[acc_bit];
            res_next.free_index = '0;
            res_next.found      = 1'b0;
        end
        else if (ctl.emit_none)
        begin
            res_next = '0;
        end
        else if (ctl.emit_found)
        begin
            res_next.bit_value  = 1'b0;
            res_next.free_index = IDX_W'({word_reg, first_zero(map_q)});
            res_next.found      = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= request;
        end
        if (ctl.word_latch)
        begin
            word_reg <= hit_word;
        end
        res_reg <= res_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

### src/free_block_bitmap_allocator.sv
// Free-block bitmap allocator: one bit per block, 1 = used. After reset the
// block sweeps the map to all-free, one 64-bit map word per cycle
// (MAP_SEGMENTS * BITS_PER_SEGMENT / 64 words, 512 by default), with busy
// high. A transaction is taken when start is high and busy is low. Test reads
// the map memory once; mark used and mark free each take one read and one
// write of it. Each then pulses done. Find-free walks a summary memory that
// keeps one "word full" bit per map word, 64 map words per summary entry,
// reading one summary entry at a time, then reads the chosen map word and
// pulses done (at most 8 summary entries are examined by default); when
// nothing free is in range, done pulses with found low. The result appears
// on result when done is high and stays until the next result replaces it;
// take it then.
module free_block_bitmap_allocator #(
    parameter int MAP_SEGMENTS     = fbba_pkg::MAP_SEGMENTS_DEF,
    parameter int BITS_PER_SEGMENT = fbba_pkg::BITS_PER_SEGMENT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  fbba_pkg::req_t               request,
    output fbba_pkg::res_t               result,
    output logic                         done,
    input  logic                         cfg_we,
    input  logic [fbba_pkg::CFG_W-1:0]   cfg_data
);
    import fbba_pkg::*;

    localparam int MAP_WORDS     = MAP_SEGMENTS * BITS_PER_SEGMENT / 64;
    localparam int WORDS_PER_SEG = BITS_PER_SEGMENT / 64;
    localparam int WC_W          = $clog2(MAP_WORDS + 1);

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] cfg_next;
    logic [WC_W-1:0]  seg_count;
    logic [WC_W-1:0]  limit_words;
    ctl_t             ctl;
    sts_t             sts;

    assign cfg_next = cfg_we ? cfg_data : cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign seg_count   = (32'(cfg_reg) > 32'(MAP_SEGMENTS)) ? WC_W'(MAP_SEGMENTS)
                                                          : WC_W'(cfg_reg);
    assign limit_words = WC_W'(seg_count * WC_W'(WORDS_PER_SEG));

    fbba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    fbba_dp #(
        .MAP_SEGMENTS     (MAP_SEGMENTS),
        .BITS_PER_SEGMENT (BITS_PER_SEGMENT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .request     (request),
        .limit_words (limit_words),
        .result      (result),
        .done        (done)
    );

endmodule
